@@ hdl/mpb_pkg.sv @@
// Shared types, codes and helper functions for the min/max pyramid builder.
// Used by mpb_ctrl, mpb_dp and minmax_pyramid_builder_core; depends on nothing.
package mpb_pkg;

    localparam int DATA_W       = 16;
    localparam int READ_INDEX_W = 13;

    // Request codes carried on req_type.
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_BUILD = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_LOAD_DROP = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SIDE_LOG2     = 2'd0;
    localparam logic [1:0] CFG_TOTAL_LEVELS  = 2'd1;
    localparam logic [1:0] CFG_STORED_LEVELS = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       accept;     // an item is taken this cycle
        logic       lvl_init;   // load the first level to build
        logic       lvl_start;  // set up addresses and counters for a level
        logic       bld_rd;     // read one child pair
        logic [1:0] child;      // which child of the 2x2 block
        logic       acc_load;   // first child data arrives
        logic       acc_upd;    // later child data arrives
        logic       bld_wr;     // write the merged parent pair
        logic       cell_step;  // advance to the next parent cell
        logic       bld_done;   // build finished, emit its result
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic lvl_last;  // no level is left to build
        logic row_last;  // current cell is the last of its row
        logic col_last;  // current row is the last of the level
    } dp_status_t;

    // Number of pairs the store must hold for the given geometry limits.
    function automatic int store_depth(input int max_side, input int max_levels);
        int total;
        total = 0;
        for (int l = 0; l < 9; l++) begin
            if (l < max_levels) begin
                total = total + (max_side >> l) * (max_side >> l);
            end
        end
        return total;
    endfunction

    // Merge two pairs: minimum of the low halves, maximum of the high halves.
    function automatic logic [2*DATA_W-1:0] pair_merge(input logic [2*DATA_W-1:0] a,
                                                       input logic [2*DATA_W-1:0] b);
        logic [DATA_W-1:0] mn;
        logic [DATA_W-1:0] mx;
        mn = (a[DATA_W-1:0] < b[DATA_W-1:0]) ? a[DATA_W-1:0] : b[DATA_W-1:0];
        mx = (a[2*DATA_W-1:DATA_W] > b[2*DATA_W-1:DATA_W]) ?
             a[2*DATA_W-1:DATA_W] : b[2*DATA_W-1:DATA_W];
        return {mx, mn};
    endfunction

endpackage

@@ hdl/mpb_ctrl.sv @@
// Controller state machine of the min/max pyramid builder.
// Sequences build passes and issues commands to mpb_dp; depends on mpb_pkg.
module mpb_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [1:0]             req_type,
    input  mpb_pkg::dp_status_t    dp_stat,
    output mpb_pkg::ctrl_cmd_t     cmd,
    output logic                   busy
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_LEVEL = 4'b0010,
        S_READ  = 4'b0100,
        S_WRITE = 4'b1000
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] child_reg;
    logic [1:0] child_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            child_reg <= 2'd0;
        end else begin
            state_reg <= state_next;
            child_reg <= child_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        child_next = child_reg;
        cmd        = '0;
        cmd.child  = child_reg;
        unique case (state_reg)
            S_IDLE: begin
                cmd.accept = start;
                if (start && (req_type == mpb_pkg::REQ_BUILD)) begin
                    cmd.lvl_init = 1'b1;
                    state_next   = S_LEVEL;
                end
            end
            S_LEVEL: begin
                if (dp_stat.lvl_last) begin
                    cmd.bld_done = 1'b1;
                    state_next   = S_IDLE;
                end else begin
                    cmd.lvl_start = 1'b1;
                    child_next    = 2'd0;
                    state_next    = S_READ;
                end
            end
            S_READ: begin
                cmd.bld_rd   = 1'b1;
                cmd.acc_load = (child_reg == 2'd1);
                cmd.acc_upd  = (child_reg == 2'd2) || (child_reg == 2'd3);
                child_next   = child_reg + 2'd1;
                if (child_reg == 2'd3) begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                cmd.bld_wr    = 1'b1;
                cmd.cell_step = 1'b1;
                child_next    = 2'd0;
                if (dp_stat.row_last && dp_stat.col_last) begin
                    state_next = S_LEVEL;
                end else begin
                    state_next = S_READ;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

@@ hdl/mpb_dp.sv @@
// Datapath of the min/max pyramid builder: configuration registers, pair store,
// build address counters, merge unit and result registers; depends on mpb_pkg.
module mpb_dp #(
    parameter int MAX_SIDE   = 64,
    parameter int MAX_LEVELS = 7
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mpb_pkg::ctrl_cmd_t                cmd,
    output mpb_pkg::dp_status_t               dp_stat,
    input  logic [1:0]                        req_type,
    input  logic                              first_item,
    input  logic [mpb_pkg::DATA_W-1:0]        cell_min,
    input  logic [mpb_pkg::DATA_W-1:0]        cell_max,
    input  logic [mpb_pkg::READ_INDEX_W-1:0]  read_index,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [2:0]                        cfg_data,
    output logic                              done,
    output logic [mpb_pkg::DATA_W-1:0]        out_min,
    output logic [mpb_pkg::DATA_W-1:0]        out_max,
    output logic [1:0]                        status
);

    localparam int DEPTH  = mpb_pkg::store_depth(MAX_SIDE, MAX_LEVELS);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int PTR_W  = $clog2(DEPTH + 1);
    localparam int MAXLOG = $clog2(MAX_SIDE + 1) - 1;
    localparam int CNT_W  = MAXLOG;
    localparam int CMP_W  = (PTR_W > mpb_pkg::READ_INDEX_W) ? PTR_W : mpb_pkg::READ_INDEX_W;
    localparam int PAIR_W = 2 * mpb_pkg::DATA_W;

    // Offset of level m in the flat store. Level sides are powers of two, so
    // the offset is a sum of distinct powers of four: one set bit per level.
    function automatic logic [PTR_W-1:0] lvl_offset(input logic [3:0] sl,
                                                    input logic [3:0] m);
        logic [PTR_W-1:0] off;
        off = '0;
        for (int k = 0; k <= MAXLOG; k++) begin
            if ((4'(k) <= sl) && ((5'(k) + {1'b0, m}) >= ({1'b0, sl} + 5'd1))) begin
                off[2*k] = 1'b1;
            end
        end
        return off;
    endfunction

    logic [2:0]        side_log2_reg;
    logic [2:0]        total_levels_reg;
    logic [2:0]        stored_levels_reg;

    logic [PAIR_W-1:0] mem [DEPTH];
    logic [PAIR_W-1:0] rdata_reg;

    logic [PTR_W-1:0]  wp_reg;
    logic [3:0]        lvl_reg;
    logic [PTR_W-1:0]  base_reg;
    logic [PTR_W-1:0]  dst_reg;
    logic [CNT_W-1:0]  ix_reg;
    logic [CNT_W-1:0]  iz_reg;
    logic [PAIR_W-1:0] acc_reg;

    logic              s1_valid_reg;
    logic              s1_read_reg;
    logic [1:0]        s1_status_reg;
    logic              done_reg;
    logic [mpb_pkg::DATA_W-1:0] out_min_reg;
    logic [mpb_pkg::DATA_W-1:0] out_max_reg;
    logic [1:0]        status_reg;

    logic [3:0]        sl_eff;
    logic [3:0]        lev_eff;
    logic [PTR_W-1:0]  size;
    logic [3:0]        shamt;
    logic [PTR_W-1:0]  side;
    logic [CNT_W-1:0]  side_m1;
    logic [PTR_W-1:0]  src_off;
    logic [PTR_W-1:0]  dst_off;
    logic [PTR_W-1:0]  bld_addr;
    logic [PTR_W-1:0]  wp_eff;
    logic              load_ok;
    logic              read_ok;
    logic [CMP_W-1:0]  ridx_ext;
    logic              is_load;
    logic              is_read;
    logic              is_build;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [IDX_W-1:0]  mem_raddr;
    logic [PAIR_W-1:0] mem_wdata;
    logic [PAIR_W-1:0] merged;

    // Configuration registers; index 3 is not a register and is ignored.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            side_log2_reg     <= 3'd6;
            total_levels_reg  <= 3'd7;
            stored_levels_reg <= 3'd1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                mpb_pkg::CFG_SIDE_LOG2:     side_log2_reg     <= cfg_data;
                mpb_pkg::CFG_TOTAL_LEVELS:  total_levels_reg  <= cfg_data;
                mpb_pkg::CFG_STORED_LEVELS: stored_levels_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective geometry.
    assign sl_eff  = ({1'b0, side_log2_reg} < 4'(MAXLOG)) ? {1'b0, side_log2_reg} : 4'(MAXLOG);
    assign lev_eff = ({1'b0, total_levels_reg} < 4'(MAX_LEVELS)) ?
                     {1'b0, total_levels_reg} : 4'(MAX_LEVELS);
    assign size    = lvl_offset(sl_eff, lev_eff);

    assign shamt   = sl_eff - lvl_reg;
    assign side    = PTR_W'(1) << shamt;
    assign side_m1 = CNT_W'(side - PTR_W'(1));
    assign src_off = lvl_offset(sl_eff, lvl_reg - 4'd1);
    assign dst_off = lvl_offset(sl_eff, lvl_reg);

    assign dp_stat.lvl_last = (lvl_reg >= lev_eff) || (lvl_reg > sl_eff);
    assign dp_stat.row_last = (ix_reg == side_m1);
    assign dp_stat.col_last = (iz_reg == side_m1);

    // Child addresses of the 2x2 block at base_reg.
    always_comb begin
        case (cmd.child)
            2'd0:    bld_addr = base_reg;
            2'd1:    bld_addr = base_reg + PTR_W'(1);
            2'd2:    bld_addr = base_reg + (side << 1);
            default: bld_addr = base_reg + (side << 1) + PTR_W'(1);
        endcase
    end

    // Item decode at the accept edge.
    assign is_load  = cmd.accept && (req_type == mpb_pkg::REQ_LOAD);
    assign is_read  = cmd.accept && (req_type == mpb_pkg::REQ_READ);
    assign is_build = cmd.accept && (req_type == mpb_pkg::REQ_BUILD);
    assign wp_eff   = first_item ? '0 : wp_reg;
    assign load_ok  = (wp_eff < size);
    assign ridx_ext = CMP_W'(read_index);
    assign read_ok  = (ridx_ext < CMP_W'(size));

    assign merged    = mpb_pkg::pair_merge(acc_reg, rdata_reg);
    assign mem_we    = (is_load && load_ok) || cmd.bld_wr;
    assign mem_waddr = cmd.bld_wr ? dst_reg[IDX_W-1:0] : wp_eff[IDX_W-1:0];
    assign mem_wdata = cmd.bld_wr ? merged : {cell_max, cell_min};
    assign mem_raddr = cmd.bld_rd ? bld_addr[IDX_W-1:0] : ridx_ext[IDX_W-1:0];

    // Pair store with one write and one registered read port.
    always_ff @(posedge clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wp_reg <= '0;
        end else if (is_load) begin
            wp_reg <= load_ok ? (wp_eff + PTR_W'(1)) : wp_eff;
        end
    end

    // Build counters; no reset needed, they are set up before use.
    always_ff @(posedge clk) begin
        if (cmd.lvl_init) begin
            lvl_reg <= (stored_levels_reg == 3'd0) ? 4'd1 : {1'b0, stored_levels_reg};
        end else if (cmd.cell_step && dp_stat.row_last && dp_stat.col_last) begin
            lvl_reg <= lvl_reg + 4'd1;
        end
        if (cmd.lvl_start) begin
            base_reg <= src_off;
            dst_reg  <= dst_off;
            ix_reg   <= '0;
            iz_reg   <= '0;
        end else if (cmd.cell_step) begin
            dst_reg <= dst_reg + PTR_W'(1);
            if (dp_stat.row_last) begin
                ix_reg   <= '0;
                iz_reg   <= iz_reg + CNT_W'(1);
                base_reg <= base_reg + PTR_W'(2) + (side << 1);
            end else begin
                ix_reg   <= ix_reg + CNT_W'(1);
                base_reg <= base_reg + PTR_W'(2);
            end
        end
        if (cmd.acc_load) begin
            acc_reg <= rdata_reg;
        end else if (cmd.acc_upd) begin
            acc_reg <= merged;
        end
    end

    // Result pipeline: one stage while the store read completes, then outputs.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            s1_valid_reg <= (cmd.accept && !is_build) || cmd.bld_done;
            done_reg     <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        s1_read_reg <= is_read && read_ok;
        if (is_load && !load_ok) begin
            s1_status_reg <= mpb_pkg::ST_LOAD_DROP;
        end else if (is_read && !read_ok) begin
            s1_status_reg <= mpb_pkg::ST_BAD_INDEX;
        end else begin
            s1_status_reg <= mpb_pkg::ST_OK;
        end
        if (s1_valid_reg) begin
            out_min_reg <= s1_read_reg ? rdata_reg[mpb_pkg::DATA_W-1:0] : '0;
            out_max_reg <= s1_read_reg ? rdata_reg[PAIR_W-1:mpb_pkg::DATA_W] : '0;
            status_reg  <= s1_status_reg;
        end
    end

    assign done    = done_reg;
    assign out_min = out_min_reg;
    assign out_max = out_max_reg;
    assign status  = status_reg;

endmodule

@@ hdl/minmax_pyramid_builder_core.sv @@
// Top level of the min/max pyramid builder.
// Instantiates mpb_ctrl and mpb_dp; depends on mpb_pkg.
//
// Usage. An item is taken at a rising edge where start is high and busy is
// low; req_type selects a load, a build or a read. Every item gives exactly
// one result, shown on out_min, out_max and status for one cycle while done
// is high. The receiver cannot stall, so results are never held back. Loads
// and reads take one item per cycle unless busy is high, and busy stays low
// for them. A build raises busy the cycle after it is taken and walks the
// pair store through its single read port: four child reads and one write
// per built cell, plus a set-up step per level and one to finish. Its
// result follows in the cycle after busy falls. The configuration channel
// (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready; the user must
// see it is written only while no item is in flight, unchecked by the
// block. Reset restores the register defaults and clears the write pointer;
// the pair store is not cleared and holds nothing defined until written.
module minmax_pyramid_builder_core #(
    parameter int MAX_SIDE   = 64,
    parameter int MAX_LEVELS = 7
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        req_type,
    input  logic                              first_item,
    input  logic [mpb_pkg::DATA_W-1:0]        cell_min,
    input  logic [mpb_pkg::DATA_W-1:0]        cell_max,
    input  logic [mpb_pkg::READ_INDEX_W-1:0]  read_index,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [2:0]                        cfg_data,
    output logic                              done,
    output logic [mpb_pkg::DATA_W-1:0]        out_min,
    output logic [mpb_pkg::DATA_W-1:0]        out_max,
    output logic [1:0]                        status
);

    mpb_pkg::ctrl_cmd_t  cmd;
    mpb_pkg::dp_status_t dp_stat;

    // Registers are plain flops with no side effects, so writes are always taken.
    assign cfg_ready = 1'b1;

    mpb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .dp_stat  (dp_stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    mpb_dp #(
        .MAX_SIDE   (MAX_SIDE),
        .MAX_LEVELS (MAX_LEVELS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .dp_stat    (dp_stat),
        .req_type   (req_type),
        .first_item (first_item),
        .cell_min   (cell_min),
        .cell_max   (cell_max),
        .read_index (read_index),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .done       (done),
        .out_min    (out_min),
        .out_max    (out_max),
        .status     (status)
    );

    // A taken build always holds off further items in the next cycle.
    a_build_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req_type == mpb_pkg::REQ_BUILD)) |=> busy)
        else $error("build accepted but busy not raised");

    // Loads, reads and unknown requests report through the s1 and done registers.
    a_stream_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req_type != mpb_pkg::REQ_BUILD)) |-> ##2 done)
        else $error("streamed item did not report on time");

    // The end of a build is followed by its result.
    a_build_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |=> done)
        else $error("build finished without a result");

    // A dropped load never carries pair data.
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == mpb_pkg::ST_LOAD_DROP)) |-> ((out_min == '0) && (out_max == '0)))
        else $error("dropped load shows nonzero data");

endmodule

@@ test/tb_minmax_pyramid_builder_core.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for minmax_pyramid_builder_core: random loads, builds and reads,
// checked against a local min/max pyramid predictor. Depends on mpb_pkg and the core RTL.
module tb_minmax_pyramid_builder_core;

    localparam int MAX_SIDE      = 64;
    localparam int MAX_LEVELS    = 7;
    localparam int MAX_SIDE_LOG2 = 6;
    // Pairs in a full 64-wide, 7-level pyramid: 4096 + 1024 + ... + 1.
    localparam int STORE_DEPTH   = 5461;
    localparam int INDEX_SPAN    = 8192;
    localparam int ITEM_TARGET   = 1150;
    // Phases with at most this many pairs get a complete load before anything else.
    localparam int FULL_LOAD_MAX = 400;
    // The limit covers the slowest legal build seen here and a full 64-wide
    // build several times over.
    localparam int STALL_LIMIT   = 40000;

    // The request code the block ignores; it still answers with an all-zero result.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  kind;
        logic        first;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [12:0] idx;
    } pyr_request_t;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [1:0]  st;
    } pyr_response_t;

    // Clock, reset and every block input start at known values.
    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        start      = 1'b0;
    logic [1:0]  req_type   = mpb_pkg::REQ_LOAD;
    logic        first_item = 1'b0;
    logic [15:0] cell_min   = '0;
    logic [15:0] cell_max   = '0;
    logic [12:0] read_index = '0;
    logic        cfg_valid  = 1'b0;
    logic [1:0]  cfg_index  = mpb_pkg::CFG_SIDE_LOG2;
    logic [2:0]  cfg_data   = '0;

    logic        busy;
    logic        cfg_ready;
    logic        done;
    logic [15:0] out_min;
    logic [15:0] out_max;
    logic [1:0]  status;

    minmax_pyramid_builder_core #(
        .MAX_SIDE   (MAX_SIDE),
        .MAX_LEVELS (MAX_LEVELS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .first_item (first_item),
        .cell_min   (cell_min),
        .cell_max   (cell_max),
        .read_index (read_index),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .done       (done),
        .out_min    (out_min),
        .out_max    (out_max),
        .status     (status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state. The register copies follow every accepted register
    // write; the pair store and the write pointer follow accepted items.
    // ------------------------------------------------------------------
    logic [2:0]  cfg_side   = 3'd6;
    logic [2:0]  cfg_total  = 3'd7;
    logic [2:0]  cfg_stored = 3'd1;
    logic [31:0] model_store [0:STORE_DEPTH-1];
    int          model_wptr = 0;

    pyr_request_t  request_queue[$];
    pyr_response_t pending_responses[$];
    int            mismatch_count = 0;

    // Side length of one level; levels past the single-cell level hold nothing.
    function automatic int side_at(int sl, int lvl);
        return (lvl <= sl) ? (1 << (sl - lvl)) : 0;
    endfunction

    // Flat index of the first pair of a level; at lvl equal to the level
    // count this is the size of the whole pyramid.
    function automatic int level_base(int sl, int lvl);
        int off;
        int i;
        int s;
        off = 0;
        for (i = 0; i < lvl; i++)
        begin
            s = side_at(sl, i);
            off += s * s;
        end
        return off;
    endfunction

    // A side beyond the store's widest sector saturates.
    function automatic int eff_side();
        return (cfg_side > MAX_SIDE_LOG2) ? MAX_SIDE_LOG2 : int'(cfg_side);
    endfunction

    // The level count saturates at the store's level limit.
    function automatic int eff_levels();
        return (cfg_total > MAX_LEVELS) ? MAX_LEVELS : int'(cfg_total);
    endfunction

    function automatic int cur_size();
        return level_base(eff_side(), eff_levels());
    endfunction

    // Fill every level from the first unsupplied one up to the top. Each parent
    // takes the smallest of its four child minimums and the largest of its four
    // child maximums. A stored level count of zero still starts at level one.
    function automatic void build_pyramid();
        int          sl;
        int          levels;
        int          lvl;
        int          n;
        int          src;
        int          dst;
        int          row;
        int          ix;
        int          iz;
        int          base;
        int          k;
        logic [31:0] quad [0:3];
        logic [15:0] mn;
        logic [15:0] mx;
        sl     = eff_side();
        levels = eff_levels();
        lvl    = (cfg_stored < 1) ? 1 : int'(cfg_stored);
        while (lvl < levels)
        begin
            n   = side_at(sl, lvl);
            src = level_base(sl, lvl - 1);
            dst = level_base(sl, lvl);
            row = 2 * n;
            for (iz = 0; iz < n; iz++)
            begin
                for (ix = 0; ix < n; ix++)
                begin
                    base    = src + 2 * ix + 2 * iz * row;
                    quad[0] = model_store[base];
                    quad[1] = model_store[base + 1];
                    quad[2] = model_store[base + row];
                    quad[3] = model_store[base + row + 1];
                    mn      = 16'hFFFF;
                    mx      = 16'h0000;
                    for (k = 0; k < 4; k++)
                    begin
                        if (quad[k][15:0] < mn)
                            mn = quad[k][15:0];
                        if (quad[k][31:16] > mx)
                            mx = quad[k][31:16];
                    end
                    model_store[dst + ix + iz * n] = {mx, mn};
                end
            end
            lvl++;
        end
    endfunction

    // Apply one accepted item to the predictor and return the result it must give.
    function automatic pyr_response_t apply_request(pyr_request_t rq);
        pyr_response_t rsp;
        int            sz;
        rsp.kind = rq.kind;
        rsp.lo   = '0;
        rsp.hi   = '0;
        rsp.st   = mpb_pkg::ST_OK;
        sz       = cur_size();
        case (rq.kind)
            mpb_pkg::REQ_LOAD:
            begin
                if (rq.first)
                    model_wptr = 0;
                // A load past the end of the pyramid is dropped and the pointer stays.
                if (model_wptr < sz)
                begin
                    model_store[model_wptr] = {rq.hi, rq.lo};
                    model_wptr++;
                end
                else
                    rsp.st = mpb_pkg::ST_LOAD_DROP;
            end
            mpb_pkg::REQ_BUILD:
                build_pyramid();
            mpb_pkg::REQ_READ:
            begin
                if (rq.idx < sz)
                begin
                    rsp.lo = model_store[rq.idx][15:0];
                    rsp.hi = model_store[rq.idx][31:16];
                end
                else
                    rsp.st = mpb_pkg::ST_BAD_INDEX;
            end
            default:
                ;
        endcase
        return rsp;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus bookkeeping. The store is undefined until written, so the
    // generator tracks which flat entries hold data and never asks for a
    // read or a build that would touch anything else. It follows the write
    // pointer in generation order, which is also acceptance order.
    // ------------------------------------------------------------------
    bit loaded_entry [0:INDEX_SPAN-1];
    int loaded_prefix = 0;
    int gen_ptr       = 0;
    int issued        = 0;

    function automatic void mark_loaded(int i);
        loaded_entry[i] = 1'b1;
        while (loaded_prefix < STORE_DEPTH && loaded_entry[loaded_prefix])
            loaded_prefix++;
    endfunction

    function automatic void issue(pyr_request_t rq);
        request_queue.insert(request_queue.size(), rq);
        issued++;
    endfunction

    // Fields that the request type does not use still carry random values.
    function automatic pyr_request_t noisy_request(logic [1:0] kind);
        pyr_request_t rq;
        rq.kind  = kind;
        rq.first = 1'($urandom_range(0, 1));
        rq.lo    = 16'($urandom_range(0, 65535));
        rq.hi    = 16'($urandom_range(0, 65535));
        rq.idx   = 13'($urandom_range(0, INDEX_SPAN - 1));
        return rq;
    endfunction

    // Heights lean toward the two extremes so that ties and saturation show up.
    function automatic logic [15:0] rnd_height();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic void queue_load(bit first, logic [15:0] lo, logic [15:0] hi);
        pyr_request_t rq;
        rq       = noisy_request(mpb_pkg::REQ_LOAD);
        rq.first = first;
        rq.lo    = lo;
        rq.hi    = hi;
        if (first)
            gen_ptr = 0;
        if (gen_ptr < cur_size())
        begin
            mark_loaded(gen_ptr);
            gen_ptr++;
        end
        issue(rq);
    endfunction

    // An in-range index that was never written is moved past the pyramid end.
    function automatic void queue_read(int idx);
        pyr_request_t rq;
        int           sz;
        sz = cur_size();
        if (idx < sz && !loaded_entry[idx])
            idx = $urandom_range(sz, INDEX_SPAN - 1);
        rq     = noisy_request(mpb_pkg::REQ_READ);
        rq.idx = 13'(idx);
        issue(rq);
    endfunction

    function automatic int pick_index();
        int sz;
        int lim;
        sz  = cur_size();
        lim = (loaded_prefix < sz) ? loaded_prefix : sz;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
                return (lim > 0) ? $urandom_range(0, lim - 1) : $urandom_range(0, INDEX_SPAN - 1);
            6, 7:
                return $urandom_range(0, INDEX_SPAN - 1);
            8:
                return sz;
            default:
                return $urandom_range(STORE_DEPTH, INDEX_SPAN - 1);
        endcase
    endfunction

    // A build is issued only when the level it starts from holds data everywhere.
    // Levels it fills count as written from then on. Returns 0 when refused.
    function automatic bit try_build();
        int sl;
        int levels;
        int s;
        int i;
        sl     = eff_side();
        levels = eff_levels();
        s      = (cfg_stored < 1) ? 1 : int'(cfg_stored);
        if (s < levels)
        begin
            for (i = level_base(sl, s - 1); i < level_base(sl, s); i++)
                if (!loaded_entry[i])
                    return 1'b0;
            for (i = level_base(sl, s); i < level_base(sl, levels); i++)
                mark_loaded(i);
        end
        issue(noisy_request(mpb_pkg::REQ_BUILD));
        return 1'b1;
    endfunction

    // The normal flow: a complete load from entry zero, maybe a dropped extra
    // load or two, then a build of the missing levels.
    function automatic void fill_pyramid(int sz);
        int i;
        queue_load(1'b1, rnd_height(), rnd_height());
        for (i = 1; i < sz; i++)
            queue_load(1'b0, rnd_height(), rnd_height());
        repeat ($urandom_range(0, 2))
            queue_load(1'b0, rnd_height(), rnd_height());
        if (!try_build())
            queue_read(pick_index());
    endfunction

    function automatic void mix_item(int sz);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            queue_read(pick_index());
        else if (pick < 62)
            queue_load($urandom_range(0, 9) == 0, rnd_height(), rnd_height());
        else if (pick < 78)
        begin
            if (!try_build())
                queue_read(pick_index());
        end
        else if (pick < 84)
            issue(noisy_request(REQ_UNUSED));
        else if (pick < 88 && sz > 0 && sz <= 32)
            fill_pyramid(sz);
        else
            queue_read(pick_index());
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [31:0] got_v, logic [31:0] want_v);
        mismatch_count++;
        if (mismatch_count <= 200)
            $display("[%0t] MISMATCH %s: got %0h, expected %0h", $time, what, got_v, want_v);
    endtask

    // ------------------------------------------------------------------
    // Item driver. An item stays on the ports until an edge with start high
    // and busy low takes it; that edge also runs the predictor. The sender
    // works in bursts of random length with random gaps, and some bursts run
    // back to back with no gap at all.
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge clk)
    begin : feed_proc
        pyr_request_t cur;
        pyr_request_t nxt;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                cur.kind  = req_type;
                cur.first = first_item;
                cur.lo    = cell_min;
                cur.hi    = cell_max;
                cur.idx   = read_index;
                pending_responses.insert(pending_responses.size(), apply_request(cur));
            end
            // Only while busy holds the current item off does it stay as it is.
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    start    <= 1'b0;
                end
                else if (request_queue.size() != 0)
                begin
                    nxt         = request_queue.pop_front();
                    start      <= 1'b1;
                    req_type   <= nxt.kind;
                    first_item <= nxt.first;
                    cell_min   <= nxt.lo;
                    cell_max   <= nxt.hi;
                    read_index <= nxt.idx;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 16);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor. The block shows each result for exactly one cycle, so
    // every edge with done high is one result, checked against the oldest
    // outstanding expectation field by field.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_proc
        pyr_response_t want;
        if (rst_n && done)
        begin
            if (pending_responses.size() == 0)
                report_mismatch("result with no item outstanding", {out_max, out_min}, 0);
            else
            begin
                want = pending_responses.pop_front();
                if (status !== want.st)
                    report_mismatch($sformatf("status, request %0d", want.kind),
                                    32'(status), 32'(want.st));
                if (out_min !== want.lo)
                    report_mismatch($sformatf("out_min, request %0d", want.kind),
                                    32'(out_min), 32'(want.lo));
                if (out_max !== want.hi)
                    report_mismatch($sformatf("out_max, request %0d", want.kind),
                                    32'(out_max), 32'(want.hi));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any taken item, result or register write restarts the count.
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Wait until every queued item has been taken and every result has come,
    // then give the block a few more cycles to settle.
    task automatic drain_all();
        while (request_queue.size() != 0 || start || pending_responses.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register writes happen only while the block is idle.
    task automatic write_reg(logic [1:0] idx, logic [2:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            mpb_pkg::CFG_SIDE_LOG2:     cfg_side   = val;
            mpb_pkg::CFG_TOTAL_LEVELS:  cfg_total  = val;
            mpb_pkg::CFG_STORED_LEVELS: cfg_stored = val;
            default:                    ;
        endcase
    endtask

    // One setting of the registers: a complete load and build when the
    // pyramid is small, a short partial load when it is large, then a random
    // mix. With pause_mid set, the sender stops until every result is back
    // before the mix starts.
    task automatic run_phase(logic [2:0] side, logic [2:0] total, logic [2:0] stored,
                             int n_mix, bit pause_mid);
        int sz;
        int i;
        write_reg(mpb_pkg::CFG_SIDE_LOG2, side);
        write_reg(mpb_pkg::CFG_TOTAL_LEVELS, total);
        write_reg(mpb_pkg::CFG_STORED_LEVELS, stored);
        sz = cur_size();
        if (sz <= FULL_LOAD_MAX)
            fill_pyramid(sz);
        else
        begin
            queue_load(1'b1, rnd_height(), rnd_height());
            repeat ($urandom_range(15, 47))
                queue_load(1'b0, rnd_height(), rnd_height());
        end
        if (pause_mid)
            drain_all();
        for (i = 0; i < n_mix; i++)
            mix_item(sz);
        drain_all();
    endtask

    initial
    begin : stimulus
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on a five-pair pyramid: a 2x2 finest level and its parent.
        write_reg(mpb_pkg::CFG_SIDE_LOG2, 3'd1);
        write_reg(mpb_pkg::CFG_TOTAL_LEVELS, 3'd2);
        write_reg(mpb_pkg::CFG_STORED_LEVELS, 3'd1);
        queue_load(1'b1, 16'h0000, 16'hFFFF);
        queue_load(1'b0, 16'hFFFF, 16'h0000);
        queue_load(1'b0, 16'h1234, 16'h8000);
        queue_load(1'b0, 16'h0001, 16'h7FFF);
        queue_load(1'b0, 16'h8000, 16'hFFFE);
        // The pyramid is full now, so this load is dropped.
        queue_load(1'b0, 16'hFFFF, 16'hFFFF);
        if (!try_build())
            queue_read(0);
        queue_read(0);
        queue_read(1);
        queue_read(2);
        queue_read(3);
        queue_read(4);
        // First index past the pyramid, then the largest index the port can carry.
        queue_read(5);
        queue_read(INDEX_SPAN - 1);
        issue('{kind: REQ_UNUSED, first: 1'b1, lo: 16'hFFFF, hi: 16'hFFFF, idx: 13'h1FFF});
        // Restart the write pointer mid-stream and rebuild over the old parent.
        queue_load(1'b1, 16'hAAAA, 16'h5555);
        if (!try_build())
            queue_read(0);
        queue_read(4);
        queue_read(0);
        drain_all();

        // Fixed settings: a single cell, stored levels of zero, more levels than
        // the side allows, nothing to build, an empty pyramid, the widest side
        // and a side past it, and stored levels above what the side allows.
        run_phase(3'd0, 3'd1, 3'd1, 30, 1'b0);
        run_phase(3'd2, 3'd3, 3'd0, 40, 1'b1);
        run_phase(3'd3, 3'd7, 3'd1, 40, 1'b0);
        run_phase(3'd2, 3'd3, 3'd3, 30, 1'b0);
        run_phase(3'd2, 3'd0, 3'd1, 25, 1'b0);
        run_phase(3'd4, 3'd5, 3'd2, 40, 1'b0);
        run_phase(3'd7, 3'd7, 3'd7, 30, 1'b0);
        run_phase(3'd6, 3'd1, 3'd0, 25, 1'b0);
        run_phase(3'd1, 3'd7, 3'd6, 30, 1'b1);
        run_phase(3'd3, 3'd4, 3'd2, 40, 1'b0);

        // Random settings, mostly small sides, until enough items have gone out.
        while (issued < ITEM_TARGET)
        begin
            run_phase(($urandom_range(0, 5) == 0) ? 3'($urandom_range(4, 7))
                                                  : 3'($urandom_range(0, 3)),
                      3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), 40,
                      $urandom_range(0, 3) == 0);
        end

        if (pending_responses.size() != 0)
            report_mismatch("results never delivered", pending_responses.size(), 0);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
